FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define CHECK_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// When the condition holds, the consequence holds in the same cycle.
`define CHECK_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// When the condition holds, the consequence holds in the next cycle.
`define CHECK_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/llr_pkg.sv
package llr_pkg;

  typedef enum logic [4:0] {
    PH_TYPE      = 5'd0,
    PH_PERM_R1   = 5'd1,
    PH_PERM_W1   = 5'd2,
    PH_PERM_X1   = 5'd3,
    PH_PERM_R2   = 5'd4,
    PH_PERM_W2   = 5'd5,
    PH_PERM_X2   = 5'd6,
    PH_PERM_R3   = 5'd7,
    PH_PERM_W3   = 5'd8,
    PH_PERM_X3   = 5'd9,
    PH_WS_FIRST  = 5'd10,
    PH_WS_MORE   = 5'd11,
    PH_SIZE_MORE = 5'd12,
    PH_SEP_FIRST = 5'd13,
    PH_SEP_MORE  = 5'd14,
    PH_NAME_MORE = 5'd15,
    PH_EOL       = 5'd16,
    PH_DISCARD   = 5'd17
  } phase_t;

  typedef enum logic [1:0] {
    ST_PENDING = 2'd0,
    ST_MATCH   = 2'd1,
    ST_ERROR   = 2'd2
  } status_t;

  typedef struct packed {
    logic is_type;
    logic is_blank;
    logic is_digit;
    logic is_zero;
    logic is_nonzero_digit;
    logic is_name_start;
    logic is_name_char;
    logic is_r;
    logic is_w;
    logic is_x;
    logic is_dash;
    logic is_suffix;
    logic is_newline;
  } llr_kind_t;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_DASH    = 8'h2d;
  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_D = 8'h44;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_UNDER   = 8'h5f;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_S = 8'h73;
  localparam logic [7:0] CH_LOWER_W = 8'h77;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;

endpackage

FILE: rtl/llr_classify.sv
module llr_classify
  import llr_pkg::*;
(
  input  logic [7:0] character,
  output llr_kind_t  kind
);

  logic letter;
  logic digit;

  assign letter = (character >= CH_LOWER_A && character <= CH_LOWER_Z) ||
                  (character >= CH_UPPER_A && character <= CH_UPPER_Z);
  assign digit  = (character >= CH_ZERO && character <= CH_NINE);

  always_comb begin
    kind.is_type = (character == CH_LOWER_D) || (character == CH_UPPER_D) ||
                   (character == CH_LOWER_B) || (character == CH_LOWER_C) ||
                   (character == CH_LOWER_P) || (character == CH_LOWER_S) ||
                   (character == CH_DASH);
    kind.is_blank         = (character == CH_SPACE) || (character == CH_TAB);
    kind.is_digit         = digit;
    kind.is_zero          = (character == CH_ZERO);
    kind.is_nonzero_digit = (character >= CH_ONE && character <= CH_NINE);
    kind.is_name_start    = letter || (character == CH_UNDER) || (character == CH_DOT);
    kind.is_name_char     = letter || digit || (character == CH_UNDER) ||
                            (character == CH_DOT);
    kind.is_r             = (character == CH_LOWER_R);
    kind.is_w             = (character == CH_LOWER_W);
    kind.is_x             = (character == CH_LOWER_X);
    kind.is_dash          = (character == CH_DASH);
    kind.is_suffix        = (character == CH_STAR) || (character == CH_SLASH);
    kind.is_newline       = (character == CH_NEWLINE);
  end

endmodule

FILE: rtl/llr_fsm.sv
`include "assert_macros.svh"

module llr_fsm
  import llr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  llr_kind_t kind,
  output status_t   status
);

  phase_t phase;
  phase_t phase_next;
  logic   reject;
  phase_t step;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_TYPE;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  always_comb begin
    reject = 1'b0;
    step   = PH_TYPE;
    status = ST_PENDING;
    unique case (phase) inside
      PH_DISCARD: begin
        step = kind.is_newline ? PH_TYPE : PH_DISCARD;
      end
      PH_PERM_R1, PH_PERM_R2, PH_PERM_R3: begin
        reject = !(kind.is_r || kind.is_dash);
        step   = phase_t'(phase + 5'd1);
      end
      PH_PERM_W1, PH_PERM_W2, PH_PERM_W3: begin
        reject = !(kind.is_w || kind.is_dash);
        step   = phase_t'(phase + 5'd1);
      end
      PH_PERM_X1, PH_PERM_X2, PH_PERM_X3: begin
        reject = !(kind.is_x || kind.is_dash);
        step   = phase_t'(phase + 5'd1);
      end
      PH_WS_FIRST: begin
        reject = !kind.is_blank;
        step   = PH_WS_MORE;
      end
      PH_WS_MORE: begin
        if (kind.is_blank) begin
          step = PH_WS_MORE;
        end else if (kind.is_zero) begin
          step = PH_SEP_FIRST;
        end else if (kind.is_nonzero_digit) begin
          step = PH_SIZE_MORE;
        end else begin
          reject = 1'b1;
        end
      end
      PH_SIZE_MORE: begin
        if (kind.is_digit) begin
          step = PH_SIZE_MORE;
        end else if (kind.is_blank) begin
          step = PH_SEP_MORE;
        end else begin
          reject = 1'b1;
        end
      end
      PH_SEP_FIRST: begin
        reject = !kind.is_blank;
        step   = PH_SEP_MORE;
      end
      PH_SEP_MORE: begin
        if (kind.is_blank) begin
          step = PH_SEP_MORE;
        end else if (kind.is_name_start) begin
          step = PH_NAME_MORE;
        end else begin
          reject = 1'b1;
        end
      end
      PH_NAME_MORE: begin
        if (kind.is_name_char) begin
          step = PH_NAME_MORE;
        end else if (kind.is_suffix) begin
          step = PH_EOL;
        end else if (kind.is_newline) begin
          step   = PH_TYPE;
          status = ST_MATCH;
        end else begin
          reject = 1'b1;
        end
      end
      PH_EOL: begin
        if (kind.is_newline) begin
          step   = PH_TYPE;
          status = ST_MATCH;
        end else begin
          reject = 1'b1;
        end
      end
      default: begin
        reject = !kind.is_type;
        step   = PH_PERM_R1;
      end
    endcase

    if (reject) begin
      status     = ST_ERROR;
      phase_next = kind.is_newline ? PH_TYPE : PH_DISCARD;
    end else begin
      phase_next = step;
    end
  end

  `CHECK_NEXT(a_match_restarts, clk, rst, advance && status == ST_MATCH, phase == PH_TYPE)
  `CHECK_NEXT(a_error_discards, clk, rst,
              advance && status == ST_ERROR && !kind.is_newline, phase == PH_DISCARD)
  `CHECK_SAME(a_discard_pending, clk, rst, phase == PH_DISCARD, status == ST_PENDING)

endmodule

FILE: rtl/listing_line_recognizer_unit.sv
// Listing line recognizer.
// The character channel carries one byte of a directory-listing line per
// transaction; the status channel returns one status per character: pending,
// match (on the newline that closes a well-formed line) or error (on the
// first byte that breaks the form). After an error the rest of the line up to
// its newline is dropped with pending status.
// Both channels use valid and stall. A character is held in an input
// register, classified and checked against the line phase, and its status is
// written into an output register, so the status is offered from the output
// register after the character has passed through the input register.
// Throughput is one character per cycle while the status receiver does not stall;
// the line phase register is the only state carried from one character to the next.
// When the status receiver stalls, the output register holds its status and
// the input register holds the next character; the character channel stalls
// only while both registers are full.
// Reset empties both registers and puts the phase at the start of a line.
`include "assert_macros.svh"

module listing_line_recognizer_unit
  import llr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       character_valid,
  output logic       character_stall,
  input  logic [7:0] character,
  output logic       status_valid,
  input  logic       status_stall,
  output logic [1:0] status
);

  logic       held_valid;
  logic [7:0] held_char;
  logic       advance;
  logic       take;
  llr_kind_t  kind;
  status_t    step_status;

  assign advance         = held_valid && (!status_valid || !status_stall);
  assign character_stall = held_valid && status_valid && status_stall;
  assign take            = character_valid && !character_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held_char <= character;
    end
  end

  llr_classify u_classify (
    .character (held_char),
    .kind      (kind)
  );

  llr_fsm u_fsm (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .kind    (kind),
    .status  (step_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      status_valid <= 1'b0;
    end else if (advance) begin
      status_valid <= 1'b1;
    end else if (!status_stall) begin
      status_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status <= step_status;
    end
  end

  `CHECK_SAME(a_stall_only_when_full, clk, rst, character_stall,
              held_valid && status_valid)
  `CHECK_NEXT(a_advance_fills_output, clk, rst, advance, status_valid)
  `CHECK_ALWAYS(a_status_code_legal, clk, rst,
                !status_valid || status != 2'd3)

endmodule

FILE: bench/listing_line_recognizer_unit_test.sv
module listing_line_recognizer_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import llr_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_CHARS = 165;

  class listing_scoreboard;
    phase_t line_phase;
    status_t expected_status[$];
    int mismatches;

    function new();
      line_phase = PH_TYPE;
      mismatches = 0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_name_start(logic [7:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             c == CH_UNDER || c == CH_DOT;
    endfunction

    function status_t next_status(logic [7:0] c);
      phase_t nxt;
      status_t st;
      bit rej;
      st = ST_PENDING;
      rej = 1'b0;
      if (line_phase == PH_DISCARD) begin
        line_phase = (c == CH_NEWLINE) ? PH_TYPE : PH_DISCARD;
        return ST_PENDING;
      end
      nxt = phase_t'(line_phase + 5'd1);
      case (line_phase)
        PH_TYPE: begin
          rej = !(c == CH_LOWER_D || c == CH_UPPER_D || c == CH_LOWER_B || c == CH_LOWER_C ||
                  c == CH_LOWER_P || c == CH_LOWER_S || c == CH_DASH);
        end
        PH_PERM_R1, PH_PERM_R2, PH_PERM_R3: rej = !(c == CH_DASH || c == CH_LOWER_R);
        PH_PERM_W1, PH_PERM_W2, PH_PERM_W3: rej = !(c == CH_DASH || c == CH_LOWER_W);
        PH_PERM_X1, PH_PERM_X2, PH_PERM_X3: rej = !(c == CH_DASH || c == CH_LOWER_X);
        PH_WS_FIRST: begin
          if (is_blank(c)) nxt = PH_WS_MORE;
          else rej = 1'b1;
        end
        PH_WS_MORE: begin
          if (is_blank(c)) nxt = PH_WS_MORE;
          else if (c == CH_ZERO) nxt = PH_SEP_FIRST;
          else if (c >= CH_ONE && c <= CH_NINE) nxt = PH_SIZE_MORE;
          else rej = 1'b1;
        end
        PH_SIZE_MORE: begin
          if (is_digit(c)) nxt = PH_SIZE_MORE;
          else if (is_blank(c)) nxt = PH_SEP_MORE;
          else rej = 1'b1;
        end
        PH_SEP_FIRST: begin
          if (is_blank(c)) nxt = PH_SEP_MORE;
          else rej = 1'b1;
        end
        PH_SEP_MORE: begin
          if (is_blank(c)) nxt = PH_SEP_MORE;
          else if (is_name_start(c)) nxt = PH_NAME_MORE;
          else rej = 1'b1;
        end
        PH_NAME_MORE: begin
          if (is_name_start(c) || is_digit(c)) nxt = PH_NAME_MORE;
          else if (c == CH_STAR || c == CH_SLASH) nxt = PH_EOL;
          else if (c == CH_NEWLINE) begin
            nxt = PH_TYPE;
            st = ST_MATCH;
          end else rej = 1'b1;
        end
        default: begin
          if (c == CH_NEWLINE) begin
            nxt = PH_TYPE;
            st = ST_MATCH;
          end else rej = 1'b1;
        end
      endcase
      if (rej) begin
        st = ST_ERROR;
        nxt = (c == CH_NEWLINE) ? PH_TYPE : PH_DISCARD;
      end
      line_phase = nxt;
      return st;
    endfunction

    function void note_character(logic [7:0] c);
      expected_status.push_back(next_status(c));
    endfunction

    function void check_status(logic [1:0] got);
      status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Status %0d arrived with no transaction pending.", got);
        return;
      end
      want = expected_status.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("Status mismatch: expected %0d, got %0d.", want, got);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic character_valid = 1'b0;
  logic character_stall;
  logic [7:0] character = 8'h00;
  logic status_valid;
  logic status_stall = 1'b0;
  logic [1:0] status;

  listing_scoreboard tally = new();
  logic [7:0] line_bytes[$];
  int send_idle = 37;
  int recv_idle = 83;
  int chars_sent = 0;
  int quiet_cycles = 0;
  bit hold_request = 1'b0;

  listing_line_recognizer_unit DUT (
    .clk(clk),
    .rst(rst),
    .character_valid(character_valid),
    .character_stall(character_stall),
    .character(character),
    .status_valid(status_valid),
    .status_stall(status_stall),
    .status(status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    bit took_char;
    bit took_status;
    took_char = !rst && character_valid && !character_stall;
    took_status = !rst && status_valid && !status_stall;
    if (took_char) tally.note_character(character);
    if (took_status) tally.check_status(status);
    if (rst || took_char || took_status) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        status_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      status_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle) begin
      character_valid <= 1'b0;
      @(posedge clk);
    end
    character_valid <= 1'b1;
    character <= c;
    @(posedge clk);
    while (character_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic build_line();
    string type_chars = "dDbcps-";
    string perm_chars = "rwx";
    string name_chars = "_.aAzZqQ0919";
    int n;
    int p;
    line_bytes.delete();
    if ($urandom_range(9) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) line_bytes.push_back(8'($urandom_range(255)));
      line_bytes.push_back(CH_NEWLINE);
      return;
    end
    line_bytes.push_back(type_chars[$urandom_range(6)]);
    for (int i = 0; i < 9; i++) begin
      line_bytes.push_back($urandom_range(1) ? CH_DASH : perm_chars[i % 3]);
    end
    n = $urandom_range(1, 3);
    repeat (n) line_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    case ($urandom_range(9))
      0, 1: line_bytes.push_back(CH_ZERO);
      2: begin
        line_bytes.push_back(CH_ZERO);
        line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
      default: begin
        line_bytes.push_back(8'(CH_ONE + $urandom_range(8)));
        n = $urandom_range(4);
        repeat (n) line_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    endcase
    n = $urandom_range(1, 3);
    repeat (n) line_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    line_bytes.push_back(name_chars[$urandom_range(7)]);
    n = $urandom_range(5);
    repeat (n) line_bytes.push_back(name_chars[$urandom_range(11)]);
    case ($urandom_range(2))
      0: line_bytes.push_back(CH_STAR);
      1: line_bytes.push_back(CH_SLASH);
      default: ;
    endcase
    line_bytes.push_back(CH_NEWLINE);
    if ($urandom_range(3) == 0) begin
      p = $urandom_range(line_bytes.size() - 1);
      case ($urandom_range(8))
        0: begin
          line_bytes[p] = CH_NEWLINE;
          while (line_bytes.size() > p + 1) void'(line_bytes.pop_back());
        end
        1: line_bytes[p] = $urandom_range(1) ? CH_SPACE : CH_TAB;
        2: line_bytes[p] = 8'(CH_ZERO + $urandom_range(9));
        3: line_bytes[p] = 8'(CH_LOWER_A + $urandom_range(25));
        4: line_bytes[p] = $urandom_range(1) ? CH_STAR : CH_SLASH;
        5: line_bytes[p] = type_chars[$urandom_range(6)];
        6: line_bytes[p] = perm_chars[$urandom_range(2)];
        7: line_bytes[p] = 8'($urandom_range(128, 255));
        default: line_bytes[p] = 8'($urandom_range(255));
      endcase
    end
  endtask

  initial begin
    int send_pct[3];
    int recv_pct[3];
    int target;
    send_pct = '{37, 83, 0};
    recv_pct = '{83, 37, 0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_text("-rwxrwxrwx 0 .a/\n");
    send_text("c\n");
    send_text("D");
    send_char(8'hff);
    send_text("x\n");
    send_char(8'h00);
    send_text("\n");

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = send_pct[ph];
      recv_idle = recv_pct[ph];
      if (ph == 2) hold_request = 1'b1;
      target = chars_sent + PHASE_CHARS;
      while (chars_sent < target) begin
        build_line();
        foreach (line_bytes[i]) send_char(line_bytes[i]);
      end
    end
    character_valid <= 1'b0;

    while (tally.expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tally.mismatches == 0 && tally.expected_status.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
